// File: rtl/lwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_pkg: shared types and constants for the label window majority check
// Holds the word formats of both channels, the controller/datapath link
// structs and the fixed field widths.
// ----------------------------------------------------------------------------
package lwm_pkg;

    localparam int LWM_MAX_WIDTH  = 256;
    localparam int LWM_MAX_HEIGHT = 256;
    localparam int LWM_MAX_WINDOW = 32;
    localparam int LWM_LABEL_BITS = 8;

    localparam int POS_W    = 8;
    localparam int LABEL_W  = 8;
    localparam int COUNT_W  = 11;
    localparam int WIN_W    = 6;
    localparam int DIM_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    // Window bounds reach at most the largest centre plus half the widest window.
    localparam int CRD_W    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LABEL_W-1:0] label;
        logic               cell_empty;
    } item_word_t;

    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] mismatch_count;
        logic [COUNT_W-1:0] counted_cells;
    } result_word_t;

    typedef struct packed {
        logic write_cell;
        logic load_query;
        logic setup;
        logic scan_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic range_empty;
        logic last_cell;
    } dp_status_t;

endpackage

// File: rtl/lwm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_ctrl: sequencer for the label window majority check
// Accepts words, steps the datapath through bound setup and the window
// scan, and strobes the result.
// ----------------------------------------------------------------------------
module lwm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               item_kind,
    input  lwm_pkg::dp_status_t status,
    output lwm_pkg::ctrl_cmd_t  cmd,
    output logic               busy,
    output logic               result_valid
);
    import lwm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       idle;

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (item_kind == KIND_QUERY))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_CHECK;
            ST_CHECK: state_next = status.range_empty ? ST_DONE : ST_SCAN;
            ST_SCAN:
            begin
                if (status.last_cell)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.write_cell = idle && start && (item_kind == KIND_WRITE);
    assign cmd.load_query = idle && start && (item_kind == KIND_QUERY);
    assign cmd.setup      = (state_reg == ST_SETUP);
    assign cmd.scan_step  = (state_reg == ST_SCAN);
    assign busy           = !idle;
    assign result_valid   = (state_reg == ST_DONE);

endmodule

// File: rtl/lwm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_dpath: label map, window bounds, scan counters and tallies
// Holds the configuration registers and the cell memory, walks the window
// one cell per cycle and counts occupied and mismatching cells.
// ----------------------------------------------------------------------------
module lwm_dpath #(
    parameter int MAX_WIDTH  = lwm_pkg::LWM_MAX_WIDTH,
    parameter int MAX_HEIGHT = lwm_pkg::LWM_MAX_HEIGHT,
    parameter int MAX_WINDOW = lwm_pkg::LWM_MAX_WINDOW,
    parameter int LABEL_BITS = lwm_pkg::LWM_LABEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lwm_pkg::ctrl_cmd_t                cmd,
    input  lwm_pkg::item_word_t               item,
    input  logic                              cfg_write,
    input  logic [lwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lwm_pkg::CFG_DAT_W-1:0]     cfg_data,
    output lwm_pkg::dp_status_t               status,
    output lwm_pkg::result_word_t             result
);
    import lwm_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W = LABEL_BITS + 1;
    localparam int CELLS   = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_RAW = $clog2(CELLS + 1);
    localparam int CNT_W   = (CNT_RAW > COUNT_W) ? CNT_RAW : COUNT_W;
    localparam int SW      = 11;

    // Configuration registers.
    logic [WIN_W-1:0] window_size_reg;
    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] map_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(8);
            map_width_reg   <= DIM_W'(256);
            map_height_reg  <= DIM_W'(256);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_WINDOW_SIZE)
            begin
                window_size_reg <= cfg_data[WIN_W-1:0];
            end
            else if (cfg_index == REG_MAP_WIDTH)
            begin
                map_width_reg <= cfg_data[DIM_W-1:0];
            end
            else if (cfg_index == REG_MAP_HEIGHT)
            begin
                map_height_reg <= cfg_data[DIM_W-1:0];
            end
        end
    end

    // Latched query.
    logic [POS_W-1:0]      qx_reg;
    logic [POS_W-1:0]      qy_reg;
    logic [LABEL_BITS-1:0] qlab_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            qx_reg   <= item.pos_x;
            qy_reg   <= item.pos_y;
            qlab_reg <= LABEL_BITS'(item.label);
        end
    end

    // Window bounds. The upper bound never goes negative, since centre plus
    // (size minus centre) is the size itself.
    logic [6:0]          ws_sat;
    logic signed [SW-1:0] half_s;
    logic signed [SW-1:0] dx_s;
    logic signed [SW-1:0] dy_s;
    logic signed [SW-1:0] x1_s;
    logic signed [SW-1:0] y1_s;
    logic [CRD_W-1:0]    x0_c;
    logic [CRD_W-1:0]    y0_c;
    logic [CRD_W-1:0]    x1_c;
    logic [CRD_W-1:0]    y1_c;
    logic [CRD_W-1:0]    x1_clamp;
    logic [CRD_W-1:0]    y1_clamp;

    always_comb
    begin
        ws_sat = ({1'b0, window_size_reg} > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW)
                                                            : {1'b0, window_size_reg};
        half_s = $signed({{(SW-6){1'b0}}, ws_sat[6:1]});
        dx_s   = $signed({2'b00, map_width_reg})  - $signed({3'b000, qx_reg});
        dy_s   = $signed({2'b00, map_height_reg}) - $signed({3'b000, qy_reg});
        x1_s   = $signed({3'b000, qx_reg}) + ((half_s < dx_s) ? half_s : dx_s);
        y1_s   = $signed({3'b000, qy_reg}) + ((half_s < dy_s) ? half_s : dy_s);
        x1_c   = x1_s[CRD_W-1:0];
        y1_c   = y1_s[CRD_W-1:0];
        x0_c   = ({2'b00, qx_reg} > CRD_W'(ws_sat[6:1])) ?
                 CRD_W'({2'b00, qx_reg} - CRD_W'(ws_sat[6:1])) : '0;
        y0_c   = ({2'b00, qy_reg} > CRD_W'(ws_sat[6:1])) ?
                 CRD_W'({2'b00, qy_reg} - CRD_W'(ws_sat[6:1])) : '0;
        // The range stops at the edge of the store, so no read falls beyond it.
        x1_clamp = (32'(x1_c) > MAX_WIDTH)  ? CRD_W'(MAX_WIDTH)  : x1_c;
        y1_clamp = (32'(y1_c) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : y1_c;
    end

    logic [CRD_W-1:0] x0_reg;
    logic [CRD_W-1:0] x1_reg;
    logic [CRD_W-1:0] y1_reg;
    logic [CRD_W-1:0] cx_reg;
    logic [CRD_W-1:0] cy_reg;
    logic [CRD_W-1:0] cx_inc;
    logic [CRD_W-1:0] cy_inc;
    logic             row_end;

    assign cx_inc  = cx_reg + CRD_W'(1);
    assign cy_inc  = cy_reg + CRD_W'(1);
    assign row_end = (cx_inc == x1_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            x0_reg <= x0_c;
            x1_reg <= x1_clamp;
            y1_reg <= y1_clamp;
            cx_reg <= x0_c;
            cy_reg <= y0_c;
        end
        else if (cmd.scan_step)
        begin
            if (row_end)
            begin
                cx_reg <= x0_reg;
                cy_reg <= cy_inc;
            end
            else
            begin
                cx_reg <= cx_inc;
            end
        end
    end

    assign status.range_empty = (cx_reg >= x1_reg) || (cy_reg >= y1_reg);
    assign status.last_cell   = row_end && (cy_inc == y1_reg);

    // Cell memory: one write port while idle, one registered read port for the scan.
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_in_range;

    assign wr_in_range = (32'(item.pos_x) < MAX_WIDTH) && (32'(item.pos_y) < MAX_HEIGHT);
    assign wr_addr = ADDR_W'(32'(item.pos_y) * MAX_WIDTH + 32'(item.pos_x));
    assign rd_addr = ADDR_W'(32'(cy_reg) * MAX_WIDTH + 32'(cx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.write_cell && wr_in_range)
        begin
            mem[wr_addr] <= item.cell_empty ? '0 : {1'b1, LABEL_BITS'(item.label)};
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Tallies, fed from the registered read data in the cycle after each read.
    logic             rd_valid_reg;
    logic [CNT_W-1:0] errs_reg;
    logic [CNT_W-1:0] pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            errs_reg <= '0;
            pix_reg  <= '0;
        end
        else if (rd_valid_reg && rd_data_reg[LABEL_BITS])
        begin
            pix_reg <= pix_reg + CNT_W'(1);
            if (rd_data_reg[LABEL_BITS-1:0] != qlab_reg)
            begin
                errs_reg <= errs_reg + CNT_W'(1);
            end
        end
    end

    assign result.accepted       = !(errs_reg > (pix_reg >> 1));
    assign result.mismatch_count = errs_reg[COUNT_W-1:0];
    assign result.counted_cells  = pix_reg[COUNT_W-1:0];

endmodule

// File: rtl/label_window_majority_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_window_majority_check_core: label map with window majority queries
// Stores a map of cluster labels and answers whether a cluster holds at
// least half of the occupied cells in a window around a given position.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one word at a rising edge where start is high and
//   busy is low. A write word (kind 0) stores one map cell in that same cycle
//   and leaves busy low, so writes can stream one per cycle. A query word
//   (kind 1) raises busy and produces exactly one result word.
//   The result word appears on result for exactly one cycle with
//   result_valid high. The receiver cannot hold it off.
//   A query keeps busy high through bound setup, a range check, a scan of
//   the in-range window cells through the single read port of the cell
//   memory (one cell a cycle), a drain for the last read to land, and the
//   result cycle. A window with no cells skips the scan and the drain.
//   The reset window size is 8, an 8 by 8 window.
//   The configuration channel is always ready and updates window_size,
//   map_width and map_height; it should be written only while idle.
//   Reset returns the controller to idle and the registers to their
//   defaults. The cell memory is not cleared: each cell must be written
//   before any query window covers it.
// ----------------------------------------------------------------------------
module label_window_majority_check_core #(
    parameter int MAX_WIDTH  = lwm_pkg::LWM_MAX_WIDTH,
    parameter int MAX_HEIGHT = lwm_pkg::LWM_MAX_HEIGHT,
    parameter int MAX_WINDOW = lwm_pkg::LWM_MAX_WINDOW,
    parameter int LABEL_BITS = lwm_pkg::LWM_LABEL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lwm_pkg::item_word_t           item,
    output logic                          result_valid,
    output lwm_pkg::result_word_t         result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwm_pkg::CFG_DAT_W-1:0] cfg_data
);
    import lwm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    lwm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item_kind    (item.kind),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // The datapath owns the map memory, the registers and the tallies; the
    // result word is held in its tally registers during the result cycle.
    lwm_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW),
        .LABEL_BITS (LABEL_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

endmodule

// File: rtl/lwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_checker: port-level checks for the label window majority check
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lwm_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input lwm_pkg::item_word_t   item,
    input logic                  result_valid
);
    import lwm_pkg::*;

    // A result only comes out of a query in progress.
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside a query");

    // One query gives one result word, never two in a row.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // The block goes busy only after accepting a query word.
    a_busy_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (item.kind == KIND_QUERY)))
        else $error("busy raised without a query");

    // A write word is absorbed without occupying the block.
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.kind == KIND_WRITE)) |=> !busy)
        else $error("write word made the block busy");

    // After the result cycle the block is ready again.
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("block stayed busy after its result");

endmodule

bind label_window_majority_check_core lwm_checker u_lwm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid)
);
